// ===== sv/omni_wheel_drive_mixer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the omni wheel drive mixer
// Concurrent checks used by the RTL file, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH
`define OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWDM_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |-> (cons)) \
		else $error("omni wheel drive mixer assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define OWDM_ASSERT_AFTER(lbl, clk_i, rst_ni, ante, dly, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rst_ni)) \
		(ante) |-> ##(dly) (cons)) \
		else $error("omni wheel drive mixer assertion failed");

`endif

// ===== sv/owdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Omni wheel drive mixer package
// Direction codes, pipeline side-band types and the sine table generator.
// ----------------------------------------------------------------------------
package owdm_pkg;

	localparam logic [1:0] DIR_STOP    = 2'd0;
	localparam logic [1:0] DIR_FWD     = 2'd1;
	localparam logic [1:0] DIR_REV     = 2'd2;
	localparam logic [1:0] DIR_INVALID = 2'd3;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic       neg;
		logic [6:0] idx;
	} sidx_t;

	typedef struct packed {
		logic       swap;
		logic       neg_s;
		logic       neg_c;
		logic [8:0] ap;
		logic [8:0] spin;
	} side_t;

	typedef struct packed {
		logic [7:0] duty;
		logic [1:0] dir;
	} wheel_t;

	// Quarter-wave sine entry for k degrees, built from a Taylor series in Q2.30
	// and rounded to the requested number of fraction bits.
	function automatic logic [63:0] rom_sine(input int unsigned k, input int unsigned frac);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		int unsigned sh;
		x    = (64'(k) * PI_Q30) / 64'd180;
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		term = ((term * x2) >> 30) / 64'd6;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd20;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd42;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd72;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd110;
		acc  = acc - term;
		term = ((term * x2) >> 30) / 64'd156;
		acc  = acc + term;
		term = ((term * x2) >> 30) / 64'd210;
		acc  = acc - term;
		if (acc > ONE_Q30) begin
			acc = ONE_Q30;
		end
		sh = 30 - frac;
		return (acc + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// Maps a whole angle 0..359 onto a table index and a sign.
	function automatic sidx_t sine_index(input logic [8:0] t);
		sidx_t      res;
		logic [1:0] q;
		logic [8:0] r;
		if (t < 9'd90) begin
			q = 2'd0;
			r = t;
		end else if (t < 9'd180) begin
			q = 2'd1;
			r = t - 9'd90;
		end else if (t < 9'd270) begin
			q = 2'd2;
			r = t - 9'd180;
		end else begin
			q = 2'd3;
			r = t - 9'd270;
		end
		res.neg = q[1];
		res.idx = q[0] ? 7'(9'd90 - r) : r[6:0];
		return res;
	endfunction

endpackage

// ===== sv/omni_wheel_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// Omni wheel drive mixer
// Kinematic mixer for a four-wheel X omni base: heading, drive power and spin
// power in, a PWM duty and a direction for each wheel out.
// ----------------------------------------------------------------------------
// A request is taken at a rising clock edge with start high and busy low. The
// block is a pipeline with no stall, so busy is low at all times except for
// the first cycle after reset, and a new request may come in every cycle.
// Each result appears on the duty and dir ports for exactly one cycle with
// done high; the receiver must take it then.
// Most stages form the restoring divider that rescales the smaller wheel term,
// one quotient bit per stage over FRAC_BITS + 9 stages; four stages come
// before it (heading reduction, quadrant decode, sine table, product) and
// two after it (spin add, clamp). Throughput is one request per cycle.
// Reset clears every valid bit, so no result comes out of stale data.
// ----------------------------------------------------------------------------
`include "omni_wheel_drive_mixer_assert.svh"

module omni_wheel_drive_mixer #(
	parameter int FRAC_BITS = 16,
	parameter int DUTY_MAX  = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [8:0]        heading_deg,
	input  logic signed [8:0] drive_power,
	input  logic signed [8:0] spin_power,
	output logic              done,
	output logic [7:0]        duty_back_right,
	output logic [1:0]        dir_back_right,
	output logic [7:0]        duty_front_right,
	output logic [1:0]        dir_front_right,
	output logic [7:0]        duty_front_left,
	output logic [1:0]        dir_front_left,
	output logic [7:0]        duty_back_left,
	output logic [1:0]        dir_back_left
);

	localparam int RW      = FRAC_BITS + 1;
	localparam int PW      = RW + 9;
	localparam int QW      = FRAC_BITS + 9;
	localparam int SW      = FRAC_BITS + 11;
	localparam int MW      = SW - FRAC_BITS;
	localparam int CW      = 13;
	localparam int LATENCY = QW + 6;

	logic busy_q;
	logic accept;

	logic [RW-1:0] sine_rom [0:90];

	logic       vld_s1;
	logic [8:0] t_s1;
	logic [8:0] ap_s1;
	logic [8:0] spin_s1;

	logic              vld_s2;
	owdm_pkg::sidx_t   si_s2;
	owdm_pkg::sidx_t   ci_s2;
	logic [8:0]        ap_s2;
	logic [8:0]        spin_s2;

	logic              vld_s3;
	logic [RW-1:0]     mx_s3;
	logic [RW-1:0]     mn_s3;
	owdm_pkg::side_t   side_s3;

	logic              vld_s4;
	logic [PW-1:0]     prod_s4;
	logic [RW-1:0]     mx_s4;
	owdm_pkg::side_t   side_s4;

	logic              dv_vld_s5  [1:QW];
	logic [RW-1:0]     dv_rem_s5  [1:QW];
	logic [QW-1:0]     dv_num_s5  [1:QW];
	logic [QW-1:0]     dv_quo_s5  [1:QW];
	logic [RW-1:0]     dv_mx_s5   [1:QW];
	owdm_pkg::side_t   dv_side_s5 [1:QW];

	logic                 vld_s6;
	logic signed [SW-1:0] sum_br_s6;
	logic signed [SW-1:0] sum_fr_s6;
	logic signed [SW-1:0] sum_fl_s6;
	logic signed [SW-1:0] sum_bl_s6;

	logic             vld_s7;
	owdm_pkg::wheel_t br_s7;
	owdm_pkg::wheel_t fr_s7;
	owdm_pkg::wheel_t fl_s7;
	owdm_pkg::wheel_t bl_s7;

	logic [8:0]       h_red;
	logic [8:0]       t_raw;
	logic [8:0]       t_in;
	logic [8:0]       ap_in;
	logic [8:0]       tc;
	logic [RW-1:0]    as_v;
	logic [RW-1:0]    ac_v;
	owdm_pkg::side_t  side_in;

	logic [QW-1:0]        q_full;
	logic [QW-1:0]        qa;
	logic [QW-1:0]        qc;
	logic signed [SW-1:0] a_q;
	logic signed [SW-1:0] c_q;
	logic signed [SW-1:0] rot_q;

	logic dir_legal;

	function automatic owdm_pkg::wheel_t wheel_out(input logic signed [SW-1:0] sum);
		owdm_pkg::wheel_t res;
		logic             neg;
		logic [SW-1:0]    mag_full;
		logic [MW-1:0]    mag;
		logic [CW-1:0]    mag_c;
		neg      = sum[SW-1];
		mag_full = neg ? SW'(-sum) : SW'(sum);
		mag      = mag_full[SW-1:FRAC_BITS];
		mag_c    = CW'(mag);
		if (mag_c > CW'(DUTY_MAX)) begin
			mag_c = CW'(DUTY_MAX);
		end
		res.duty = mag_c[7:0];
		if (mag_c == '0) begin
			res.dir = owdm_pkg::DIR_STOP;
		end else if (neg) begin
			res.dir = owdm_pkg::DIR_REV;
		end else begin
			res.dir = owdm_pkg::DIR_FWD;
		end
		return res;
	endfunction

	for (genvar k = 0; k <= 90; k++) begin : g_rom
		localparam logic [RW-1:0] SINE_K = RW'(owdm_pkg::rom_sine(k, FRAC_BITS));
		assign sine_rom[k] = SINE_K;
	end

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Stage 1: heading reduction, the mirrored angle and the drive magnitude.
	always_comb begin
		h_red = (heading_deg >= 9'd360) ? heading_deg - 9'd360 : heading_deg;
		t_raw = 9'd405 - h_red;
		t_in  = (t_raw >= 9'd360) ? t_raw - 9'd360 : t_raw;
		ap_in = drive_power[8] ? (~drive_power + 9'd1) : drive_power;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_in;
		ap_s1   <= ap_in;
		spin_s1 <= spin_power;
	end

	// Stage 2: quadrant decode for sine and cosine.
	assign tc = (t_s1 >= 9'd270) ? t_s1 - 9'd270 : t_s1 + 9'd90;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		si_s2   <= owdm_pkg::sine_index(t_s1);
		ci_s2   <= owdm_pkg::sine_index(tc);
		ap_s2   <= ap_s1;
		spin_s2 <= spin_s1;
	end

	// Stage 3: table lookup and ordering of the two magnitudes.
	always_comb begin
		as_v          = sine_rom[si_s2.idx];
		ac_v          = sine_rom[ci_s2.idx];
		side_in.swap  = as_v > ac_v;
		side_in.neg_s = si_s2.neg;
		side_in.neg_c = ci_s2.neg;
		side_in.ap    = ap_s2;
		side_in.spin  = spin_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s3   <= side_in.swap ? as_v : ac_v;
		mn_s3   <= side_in.swap ? ac_v : as_v;
		side_s3 <= side_in;
	end

	// Stage 4: power times the smaller magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= PW'(side_s3.ap) * PW'(mn_s3);
		mx_s4   <= mx_s3;
		side_s4 <= side_s3;
	end

	// Stage 5: restoring divider, one quotient bit per step. The upper part of
	// the dividend is already below the divisor, so it seeds the remainder.
	for (genvar j = 1; j <= QW; j++) begin : g_div
		logic            vld_in;
		logic [RW-1:0]   rem_in;
		logic [QW-1:0]   num_in;
		logic [QW-1:0]   quo_in;
		logic [RW-1:0]   mx_in;
		owdm_pkg::side_t side_d;
		logic [RW:0]     trial;
		logic            ge;

		if (j == 1) begin : g_first
			assign vld_in = vld_s4;
			assign rem_in = prod_s4[PW-1:9];
			assign num_in = {prod_s4[8:0], {FRAC_BITS{1'b0}}};
			assign quo_in = '0;
			assign mx_in  = mx_s4;
			assign side_d = side_s4;
		end else begin : g_next
			assign vld_in = dv_vld_s5[j-1];
			assign rem_in = dv_rem_s5[j-1];
			assign num_in = dv_num_s5[j-1];
			assign quo_in = dv_quo_s5[j-1];
			assign mx_in  = dv_mx_s5[j-1];
			assign side_d = dv_side_s5[j-1];
		end

		assign trial = {rem_in, num_in[QW-1]};
		assign ge    = trial >= {1'b0, mx_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s5[j] <= 1'b0;
			end else begin
				dv_vld_s5[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s5[j]  <= ge ? RW'(trial - {1'b0, mx_in}) : RW'(trial);
			dv_num_s5[j]  <= {num_in[QW-2:0], 1'b0};
			dv_quo_s5[j]  <= {quo_in[QW-2:0], ge};
			dv_mx_s5[j]   <= mx_in;
			dv_side_s5[j] <= side_d;
		end
	end

	// Stage 6: signs, spin add.
	always_comb begin
		q_full = {dv_side_s5[QW].ap, {FRAC_BITS{1'b0}}};
		qa     = dv_side_s5[QW].swap ? dv_quo_s5[QW] : q_full;
		qc     = dv_side_s5[QW].swap ? q_full : dv_quo_s5[QW];
		a_q    = dv_side_s5[QW].neg_c ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
		c_q    = dv_side_s5[QW].neg_s ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
		rot_q  = SW'($signed({dv_side_s5[QW].spin, {FRAC_BITS{1'b0}}}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= dv_vld_s5[QW];
		end
	end

	always_ff @(posedge clk) begin
		sum_br_s6 <= a_q + rot_q;
		sum_fr_s6 <= rot_q - c_q;
		sum_fl_s6 <= c_q + rot_q;
		sum_bl_s6 <= rot_q - a_q;
	end

	// Stage 7: truncation, clamp and direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		br_s7 <= wheel_out(sum_br_s6);
		fr_s7 <= wheel_out(sum_fr_s6);
		fl_s7 <= wheel_out(sum_fl_s6);
		bl_s7 <= wheel_out(sum_bl_s6);
	end

	assign done             = vld_s7;
	assign duty_back_right  = br_s7.duty;
	assign dir_back_right   = br_s7.dir;
	assign duty_front_right = fr_s7.duty;
	assign dir_front_right  = fr_s7.dir;
	assign duty_front_left  = fl_s7.duty;
	assign dir_front_left   = fl_s7.dir;
	assign duty_back_left   = bl_s7.duty;
	assign dir_back_left    = bl_s7.dir;

	assign dir_legal = (dir_back_right != owdm_pkg::DIR_INVALID)
		&& (dir_front_right != owdm_pkg::DIR_INVALID)
		&& (dir_front_left != owdm_pkg::DIR_INVALID)
		&& (dir_back_left != owdm_pkg::DIR_INVALID);

	`OWDM_ASSERT_AFTER(a_req_gives_result, clk, arst_n, start && !busy, LATENCY, done)
	`OWDM_ASSERT_IMPL(a_result_has_req, clk, arst_n, done, $past(start && !busy, LATENCY))
	`OWDM_ASSERT_IMPL(a_dir_legal, clk, arst_n, done, dir_legal)

endmodule
